[rtl/core/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define CHK_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/lba_chs_pkg.sv]
// ----------------------------------------------------------------------------
// lba_chs_pkg
// types, constants and codes shared by the block address translator
// ----------------------------------------------------------------------------
package lba_chs_pkg;

	localparam int NUM_PARTITIONS = 4;
	localparam int PART_IW = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;

	// divider geometry
	localparam int DIV_W     = 28;
	localparam int DVSR_W    = 8;
	localparam int DIV_STEPS = 2;
	localparam int DIV_ITER  = DIV_W / DIV_STEPS;
	localparam int DIV_CNT_W = $clog2(DIV_ITER + 1);

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_PART  = 2'd1;
	localparam logic [1:0] ST_PAST_PART = 2'd2;
	localparam logic [1:0] ST_PAST_DISK = 2'd3;

	// commands
	localparam logic CMD_LOOKUP = 1'b0;
	localparam logic CMD_LOAD   = 1'b1;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_CYLINDERS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SPT       = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [3:0]  part_number;
		logic [31:0] block_offset;
		logic [31:0] entry_first;
		logic [31:0] entry_last;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] cyl_out;
		logic [3:0]  head_out;
		logic [7:0]  sector_out;
	} result_t;

endpackage

[rtl/core/lba_chs_div.sv]
// ----------------------------------------------------------------------------
// lba_chs_div
// shared restoring divider, two quotient bits per cycle
// ----------------------------------------------------------------------------
module lba_chs_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [lba_chs_pkg::DIV_W-1:0]       dividend,
	input  logic [lba_chs_pkg::DVSR_W-1:0]      divisor,
	output logic                                done,
	output logic [lba_chs_pkg::DIV_W-1:0]       quotient,
	output logic [lba_chs_pkg::DVSR_W-1:0]      remainder
);

	logic                                 active_q;
	logic                                 done_q;
	logic [lba_chs_pkg::DIV_CNT_W-1:0]    cnt_q;
	logic [lba_chs_pkg::DIV_W-1:0]        dq_q;
	logic [lba_chs_pkg::DVSR_W-1:0]       rem_q;
	logic [lba_chs_pkg::DVSR_W-1:0]       dvsr_q;
	logic [lba_chs_pkg::DIV_W-1:0]        dq_nxt;
	logic [lba_chs_pkg::DVSR_W-1:0]       rem_nxt;

	always_comb begin
		logic [lba_chs_pkg::DVSR_W:0] trial;
		logic                         ge;
		dq_nxt  = dq_q;
		rem_nxt = rem_q;
		for (int k = 0; k < lba_chs_pkg::DIV_STEPS; k++) begin
			trial   = {rem_nxt, dq_nxt[lba_chs_pkg::DIV_W-1]};
			ge      = (trial >= {1'b0, dvsr_q});
			dq_nxt  = {dq_nxt[lba_chs_pkg::DIV_W-2:0], ge};
			rem_nxt = ge ? lba_chs_pkg::DVSR_W'(trial - {1'b0, dvsr_q})
			             : trial[lba_chs_pkg::DVSR_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= lba_chs_pkg::DIV_CNT_W'(lba_chs_pkg::DIV_ITER);
			end else if (active_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == lba_chs_pkg::DIV_CNT_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q   <= dividend;
			rem_q  <= '0;
			dvsr_q <= divisor;
		end else if (active_q) begin
			dq_q  <= dq_nxt;
			rem_q <= rem_nxt;
		end
	end

	assign done      = done_q;
	assign quotient  = dq_q;
	assign remainder = rem_q;

endmodule

[rtl/core/partition_lba_to_chs.sv]
// ----------------------------------------------------------------------------
// partition_lba_to_chs
// partition-relative block address to cylinder/head/sector translator
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one
// result follows, shown for a single cycle with done high, and the receiver
// cannot stall it, so it must sample result whenever done is high. A
// partition load or a seek with a bad partition number returns directly,
// a seek past the partition end after the partition check, a seek past
// the disk after the capacity check, and a converted seek after both
// divisions: one shared divider retiring two quotient bits a cycle runs
// twice, block by sectors per track, then track by heads. The geometry port
// is ready whenever busy is low and is written only between transactions.
// ----------------------------------------------------------------------------
module partition_lba_to_chs (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   start,
	output logic                                   busy,
	input  lba_chs_pkg::req_t                      req,
	output logic                                   done,
	output lba_chs_pkg::result_t                   result,
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [lba_chs_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lba_chs_pkg::CFG_DAT_W-1:0]      cfg_data
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PART = 3'd1;
	localparam logic [2:0] S_CAP  = 3'd2;
	localparam logic [2:0] S_DISK = 3'd3;
	localparam logic [2:0] S_DIV1 = 3'd4;
	localparam logic [2:0] S_DIV2 = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0]                          state_q;
	logic [15:0]                         cyl_n_q;
	logic [4:0]                          hd_n_q;
	logic [7:0]                          spt_q;
	logic [31:0]                         first_q [lba_chs_pkg::NUM_PARTITIONS];
	logic [31:0]                         last_q  [lba_chs_pkg::NUM_PARTITIONS];
	logic [15:0]                         cur_cyl_q;
	logic [3:0]                          cur_head_q;
	logic [7:0]                          cur_sec_q;
	logic [7:0]                          new_sec_q;
	logic [1:0]                          status_q;
	logic [32:0]                         block_q;
	logic [lba_chs_pkg::PART_IW-1:0]     idx_q;
	logic                                part_nz_q;
	logic [20:0]                         prod_q;
	logic [28:0]                         cap_q;
	logic                                done_q;
	lba_chs_pkg::result_t                result_q;

	logic                                accept;
	logic [3:0]                          part_m1;
	logic [lba_chs_pkg::PART_IW-1:0]     req_idx;
	logic                                part_ok;
	logic [4:0]                          hd_eff;
	logic                                disk_ok;
	logic                                div_start;
	logic [lba_chs_pkg::DIV_W-1:0]       div_dividend;
	logic [lba_chs_pkg::DVSR_W-1:0]      div_divisor;
	logic                                div_done;
	logic [lba_chs_pkg::DIV_W-1:0]       div_quot;
	logic [lba_chs_pkg::DVSR_W-1:0]      div_rem;

	assign busy      = (state_q != S_IDLE);
	assign cfg_ready = !busy;
	assign accept    = start && !busy;
	assign part_m1   = req.part_number - 4'd1;
	assign req_idx   = part_m1[lba_chs_pkg::PART_IW-1:0];
	assign part_ok   = (req.part_number != 4'd0) &&
	                   (req.part_number <= 4'(lba_chs_pkg::NUM_PARTITIONS));
	assign hd_eff    = (hd_n_q > 5'd16) ? 5'd16 : hd_n_q;
	assign disk_ok   = (cap_q != '0) && (block_q < {4'b0, cap_q});

	assign div_start    = ((state_q == S_DISK) && disk_ok) ||
	                      ((state_q == S_DIV1) && div_done);
	assign div_dividend = (state_q == S_DISK) ? block_q[lba_chs_pkg::DIV_W-1:0] : div_quot;
	assign div_divisor  = (state_q == S_DISK) ? spt_q : {3'b0, hd_eff};

	lba_chs_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quot),
		.remainder (div_rem)
	);

	// geometry registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cyl_n_q <= 16'd1024;
			hd_n_q  <= 5'd16;
			spt_q   <= 8'd63;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				lba_chs_pkg::CFG_CYLINDERS: cyl_n_q <= cfg_data;
				lba_chs_pkg::CFG_HEADS:     hd_n_q  <= cfg_data[4:0];
				lba_chs_pkg::CFG_SPT:       spt_q   <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// partition table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lba_chs_pkg::NUM_PARTITIONS; i++) begin
				first_q[i] <= '0;
				last_q[i]  <= '0;
			end
		end else if (accept && (req.cmd == lba_chs_pkg::CMD_LOAD) && part_ok) begin
			first_q[req_idx] <= req.entry_first;
			last_q[req_idx]  <= req.entry_last;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cur_cyl_q  <= '0;
			cur_head_q <= '0;
			cur_sec_q  <= 8'd1;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.cmd == lba_chs_pkg::CMD_LOAD) begin
							state_q <= S_FIN;
						end else if ((req.part_number != 4'd0) && !part_ok) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_PART;
						end
					end
				end
				S_PART: begin
					if (part_nz_q && (block_q > {1'b0, last_q[idx_q]})) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_CAP;
					end
				end
				S_CAP: state_q <= S_DISK;
				S_DISK: state_q <= disk_ok ? S_DIV1 : S_FIN;
				S_DIV1: begin
					if (div_done) begin
						state_q <= S_DIV2;
					end
				end
				S_DIV2: begin
					if (div_done) begin
						cur_cyl_q  <= div_quot[15:0];
						cur_head_q <= div_rem[3:0];
						cur_sec_q  <= new_sec_q;
						state_q    <= S_FIN;
					end
				end
				S_FIN: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			idx_q     <= req_idx;
			part_nz_q <= (req.part_number != 4'd0);
			block_q   <= {1'b0, req.block_offset} +
			             ((req.part_number != 4'd0) ? {1'b0, first_q[req_idx]} : 33'd0);
			if (req.cmd == lba_chs_pkg::CMD_LOAD) begin
				status_q <= part_ok ? lba_chs_pkg::ST_OK : lba_chs_pkg::ST_BAD_PART;
			end else begin
				status_q <= lba_chs_pkg::ST_BAD_PART;
			end
		end
		if (state_q == S_PART) begin
			prod_q   <= 21'(cyl_n_q) * 21'(hd_eff);
			status_q <= lba_chs_pkg::ST_PAST_PART;
		end
		if (state_q == S_CAP) begin
			cap_q <= 29'(prod_q) * 29'(spt_q);
		end
		if (state_q == S_DISK) begin
			status_q <= disk_ok ? lba_chs_pkg::ST_OK : lba_chs_pkg::ST_PAST_DISK;
		end
		if ((state_q == S_DIV1) && div_done) begin
			new_sec_q <= div_rem + 8'd1;
		end
		if (state_q == S_FIN) begin
			result_q.status     <= status_q;
			result_q.cyl_out    <= cur_cyl_q;
			result_q.head_out   <= cur_head_q;
			result_q.sector_out <= cur_sec_q;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

[rtl/core/lba_chs_checker.sv]
// ----------------------------------------------------------------------------
// lba_chs_checker
// port-level checks on the translator's command and result timing
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lba_chs_checker (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic                   busy,
	input  logic                   done,
	input  lba_chs_pkg::result_t   result
);

	// a result only closes a transaction that was in flight
	`CHK_IMP(a_done_after_busy, clk, arst_n, done, $past(busy))
	// a taken transaction holds the block busy
	`CHK_NXT(a_busy_after_start, clk, arst_n, start && !busy, busy)
	// one strobe per transaction
	`CHK_NXT(a_single_strobe, clk, arst_n, done, !done)
	// sector numbers are one-based
	`CHK_IMP(a_sector_nonzero, clk, arst_n, done, result.sector_out != 8'd0)

endmodule

bind partition_lba_to_chs lba_chs_checker u_lba_chs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.result (result)
);

[bench/partition_lba_to_chs_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// partition_lba_to_chs_tb
// self-checking bench for the partition block address to chs translator
// ----------------------------------------------------------------------------
// Partition loads and seeks go in through the start/busy port under several
// disk geometries, the extremes among them. A predictor tracks the partition
// entries and the current address and works out each result when its
// transaction is taken. The monitor compares every result, field by field,
// with the oldest prediction.
// ----------------------------------------------------------------------------
module partition_lba_to_chs_tb;
	import lba_chs_pkg::*;

	localparam int STALL_LIMIT = 4000;

	typedef struct {
		req_t r;
		bit   drain;
	} pend_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 busy;
	req_t                 req = '0;
	logic                 done;
	result_t              result;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DAT_W-1:0] cfg_data = '0;

	pend_t   req_queue[$];
	result_t chs_expected[$];
	result_t want;
	int      n_pushed = 0;
	int      n_req_taken = 0;
	int      n_res_seen = 0;
	int      errors = 0;
	int      send_idle_pct = 30;
	int      idle_cycles = 0;

	// predictor copy of the geometry, partition entries and current address
	logic [15:0] geo_cyl;
	logic [4:0]  geo_heads;
	logic [7:0]  geo_spt;
	logic [31:0] part_first_sh[NUM_PARTITIONS];
	logic [31:0] part_last_sh[NUM_PARTITIONS];
	logic [15:0] cur_cyl;
	logic [3:0]  cur_head;
	logic [7:0]  cur_sector;

	// stimulus-side view, used only to aim offsets at interesting blocks
	logic [63:0] plan_cap = 64'd1032192;
	logic [31:0] plan_first[NUM_PARTITIONS] = '{default: '0};
	logic [31:0] plan_last[NUM_PARTITIONS] = '{default: '0};

	partition_lba_to_chs u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic result_t translate_request(req_t r);
		result_t     res;
		logic [63:0] blk;
		logic [63:0] cap;
		logic [63:0] track;
		logic [63:0] hd;
		res.status = ST_OK;
		hd = (geo_heads > 5'd16) ? 64'd16 : 64'(geo_heads);
		cap = 64'(geo_cyl) * hd * 64'(geo_spt);
		if (r.cmd == CMD_LOAD) begin
			if (r.part_number == 0 || r.part_number > NUM_PARTITIONS) begin
				res.status = ST_BAD_PART;
			end else begin
				part_first_sh[r.part_number - 1] = r.entry_first;
				part_last_sh[r.part_number - 1] = r.entry_last;
			end
		end else if (r.part_number > NUM_PARTITIONS) begin
			res.status = ST_BAD_PART;
		end else begin
			blk = 64'(r.block_offset);
			if (r.part_number != 0)
				blk = blk + 64'(part_first_sh[r.part_number - 1]);
			if (r.part_number != 0 && blk > 64'(part_last_sh[r.part_number - 1])) begin
				res.status = ST_PAST_PART;
			end else if (cap == 0 || blk >= cap) begin
				res.status = ST_PAST_DISK;
			end else begin
				track = blk / 64'(geo_spt);
				cur_sector = 8'(blk % 64'(geo_spt) + 64'd1);
				cur_head = 4'(track % hd);
				cur_cyl = 16'(track / hd);
			end
		end
		res.cyl_out = cur_cyl;
		res.head_out = cur_head;
		res.sector_out = cur_sector;
		return res;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			req <= '0;
		end else if (!start || !busy) begin
			if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct
			    && !(req_queue[0].drain
			         && (n_req_taken - n_res_seen + int'(start) - int'(done)) != 0)) begin
				req <= req_queue[0].r;
				start <= 1'b1;
				req_queue.pop_front();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// monitor and predictor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geo_cyl = 16'd1024;
			geo_heads = 5'd16;
			geo_spt = 8'd63;
			cur_cyl = '0;
			cur_head = '0;
			cur_sector = 8'd1;
			for (int i = 0; i < NUM_PARTITIONS; i++) begin
				part_first_sh[i] = '0;
				part_last_sh[i] = '0;
			end
		end else begin
			if (done) begin
				n_res_seen <= n_res_seen + 1;
				if (chs_expected.size() == 0) begin
					$error("result with no transaction pending: status %0d", result.status);
					errors++;
				end else begin
					want = chs_expected.pop_front();
					if (result.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, result.status);
						errors++;
					end
					if (result.cyl_out !== want.cyl_out) begin
						$error("cyl_out: expected %0d, got %0d", want.cyl_out, result.cyl_out);
						errors++;
					end
					if (result.head_out !== want.head_out) begin
						$error("head_out: expected %0d, got %0d", want.head_out,
							result.head_out);
						errors++;
					end
					if (result.sector_out !== want.sector_out) begin
						$error("sector_out: expected %0d, got %0d", want.sector_out,
							result.sector_out);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				chs_expected.push_back(translate_request(req));
				n_req_taken <= n_req_taken + 1;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_CYLINDERS: geo_cyl = cfg_data;
					CFG_HEADS:     geo_heads = cfg_data[4:0];
					CFG_SPT:       geo_spt = cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done || (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("** partition_lba_to_chs: FAILED **");
				$finish;
			end
		end
	end

	function automatic req_t seek_req(logic [3:0] p, logic [31:0] off);
		req_t r;
		r.cmd = CMD_LOOKUP;
		r.part_number = p;
		r.block_offset = off;
		r.entry_first = $urandom;
		r.entry_last = $urandom;
		return r;
	endfunction

	function automatic req_t load_req(logic [3:0] p, logic [31:0] f, logic [31:0] l);
		req_t r;
		r.cmd = CMD_LOAD;
		r.part_number = p;
		r.block_offset = $urandom;
		r.entry_first = f;
		r.entry_last = l;
		return r;
	endfunction

	task automatic add_item(req_t r, bit drain);
		pend_t item;
		item.r = r;
		item.drain = drain;
		req_queue.push_back(item);
		n_pushed++;
		if (r.cmd == CMD_LOAD && r.part_number != 0 && r.part_number <= NUM_PARTITIONS) begin
			plan_first[r.part_number - 1] = r.entry_first;
			plan_last[r.part_number - 1] = r.entry_last;
		end
	endtask

	task automatic wait_idle();
		do @(posedge clk);
		while (n_pushed != n_req_taken || n_res_seen != n_req_taken);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk);
		while (!cfg_ready);
	endtask

	task automatic set_geometry(int unsigned c, int unsigned h, int unsigned s);
		logic [63:0] hd;
		write_reg(CFG_CYLINDERS, 16'(c));
		write_reg(CFG_HEADS, {11'($urandom), 5'(h)});
		write_reg(CFG_SPT, {8'($urandom), 8'(s)});
		cfg_valid <= 1'b0;
		hd = (h > 16) ? 64'd16 : 64'(h);
		plan_cap = 64'(c) * hd * 64'(s);
	endtask

	task automatic gen_random(int count);
		int          pick;
		logic [3:0]  p;
		logic [63:0] off;
		logic [63:0] span;
		logic [63:0] lo;
		logic [63:0] hi;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 15) begin
				if ($urandom_range(99) < 85)
					p = 4'($urandom_range(1, NUM_PARTITIONS));
				else if ($urandom_range(1) == 0)
					p = 4'd0;
				else
					p = 4'($urandom_range(NUM_PARTITIONS + 1, 15));
				if ($urandom_range(9) == 0) begin
					lo = 64'($urandom);
					hi = 64'($urandom);
				end else begin
					lo = (plan_cap != 0) ? {$urandom, $urandom} % plan_cap
						: 64'($urandom_range(0, 1000));
					span = ($urandom_range(1) == 0) ? 64'($urandom_range(0, 100))
						: {$urandom, $urandom} % (plan_cap + 64'd1);
					hi = lo + span;
					if (hi > 64'hFFFF_FFFF)
						hi = 64'hFFFF_FFFF;
				end
				add_item(load_req(p, 32'(lo), 32'(hi)), $urandom_range(39) == 0);
			end else if (pick < 60) begin
				case ($urandom_range(9))
					0: off = 64'($urandom);
					1, 2: off = (plan_cap >= 2) ? plan_cap - 64'd2 + 64'($urandom_range(0, 3))
						: 64'($urandom_range(0, 3));
					default: off = {$urandom, $urandom} % (plan_cap + 64'd1);
				endcase
				add_item(seek_req(4'd0, 32'(off)), $urandom_range(39) == 0);
			end else if (pick < 95) begin
				p = 4'($urandom_range(1, NUM_PARTITIONS));
				span = (plan_last[p - 1] >= plan_first[p - 1])
					? 64'(plan_last[p - 1]) - 64'(plan_first[p - 1]) : 64'd0;
				if ($urandom_range(6) == 0)
					off = 64'($urandom);
				else
					off = {$urandom, $urandom} % (span + 64'd3);
				add_item(seek_req(p, 32'(off)), $urandom_range(39) == 0);
			end else begin
				p = 4'($urandom_range(NUM_PARTITIONS + 1, 15));
				add_item(seek_req(p, $urandom), $urandom_range(39) == 0);
			end
		end
	endtask

	int unsigned geo_c[12] = '{65535, 1, 300, 65535, 0, 777, 2, 100, 500, 0, 40000, 1024};
	int unsigned geo_h[12] = '{16, 1, 4, 31, 16, 20, 3, 0, 7, 0, 17, 16};
	int unsigned geo_s[12] = '{255, 1, 17, 255, 63, 1, 255, 63, 0, 0, 200, 63};

	initial begin
		int k;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset geometry: 1024 x 16 x 63
		add_item(seek_req(4'd0, 32'd0), 1'b0);
		add_item(seek_req(4'd0, 32'd1032191), 1'b0);
		add_item(seek_req(4'd0, 32'd1032192), 1'b0);
		add_item(seek_req(4'd0, 32'hFFFF_FFFF), 1'b0);
		add_item(seek_req(4'd1, 32'd0), 1'b0);
		add_item(seek_req(4'd1, 32'd1), 1'b0);
		add_item(load_req(4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
		add_item(load_req(4'd5, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
		add_item(load_req(4'd15, 32'd0, 32'd0), 1'b0);
		add_item(seek_req(4'd5, 32'd0), 1'b0);
		add_item(seek_req(4'd15, 32'd1), 1'b0);
		add_item(load_req(4'd1, 32'd1000, 32'd2000), 1'b0);
		add_item(seek_req(4'd1, 32'd1000), 1'b0);
		add_item(seek_req(4'd1, 32'd1001), 1'b0);
		// sum overflow past 32 bits
		add_item(load_req(4'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF), 1'b0);
		add_item(seek_req(4'd2, 32'd0), 1'b0);
		add_item(seek_req(4'd2, 32'd1), 1'b0);
		add_item(load_req(4'd3, 32'd0, 32'hFFFF_FFFF), 1'b0);
		add_item(seek_req(4'd3, 32'hFFFF_FFFF), 1'b0);
		add_item(seek_req(4'd3, 32'd63), 1'b1);
		add_item(load_req(4'd4, 32'd1032000, 32'd1032191), 1'b0);
		add_item(seek_req(4'd4, 32'd191), 1'b0);
		add_item(seek_req(4'd4, 32'd192), 1'b0);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 30 : (ph == 1) ? 76 : 0;
			for (int g = 0; g < 4; g++) begin
				k = ph * 4 + g;
				wait_idle();
				if (k == 9)
					set_geometry($urandom_range(1, 65535), $urandom_range(1, 31),
						$urandom_range(1, 255));
				else
					set_geometry(geo_c[k], geo_h[k], geo_s[k]);
				gen_random(90);
			end
		end

		wait_idle();
		repeat (50) @(posedge clk);
		if (chs_expected.size() != 0) begin
			$error("%0d results never arrived", chs_expected.size());
			errors++;
		end
		if (errors == 0)
			$display("** partition_lba_to_chs: PASSED **");
		else
			$display("** partition_lba_to_chs: FAILED **");
		$finish;
	end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/lba_chs_pkg.sv
rtl/core/lba_chs_div.sv
rtl/core/partition_lba_to_chs.sv
rtl/core/lba_chs_checker.sv
bench/partition_lba_to_chs_tb.sv
